FILE: rtl/mht_pkg.sv
package mht_pkg;

    localparam int KEY_W       = 31;
    localparam int VAL_W       = 64;
    localparam int STATUS_W    = 3;
    localparam int BUCKETS_DEF = 16;
    localparam int WAYS_DEF    = 4;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED  = 3'd0,
        STATUS_UPDATED   = 3'd1,
        STATUS_REMOVED   = 3'd2,
        STATUS_NOT_FOUND = 3'd3,
        STATUS_FULL      = 3'd4
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic             operation;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                table_empty;
    } rsp_t;

endpackage

FILE: rtl/mht_ram.sv
module mht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/mht_mod.sv
module mht_mod #(
    parameter int BUCKETS = mht_pkg::BUCKETS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mht_pkg::KEY_W-1:0]  key,
    output logic                       done,
    output logic [$clog2(BUCKETS)-1:0] rem
);

    localparam int RW     = $clog2(BUCKETS);
    localparam int KEY_W  = mht_pkg::KEY_W;
    localparam int MUL_W  = KEY_W + 1;
    localparam int PROD_W = KEY_W + MUL_W;
    localparam int SHIFT  = KEY_W + RW;
    localparam logic [63:0]      NUMER = 64'd1 << SHIFT;
    localparam logic [63:0]      RECIP = (NUMER + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [MUL_W-1:0] MUL   = MUL_W'(RECIP);
    localparam logic [RW-1:0]    BK_LO = RW'(BUCKETS);

    logic              load_reg;
    logic              mul_reg;
    logic              done_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [RW-1:0]     rem_reg;
    logic [RW-1:0]     quo_lo;

    // quotient by rounded-up reciprocal, remainder needs only its low bits
    assign quo_lo = prod_reg[SHIFT +: RW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= 1'b0;
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            load_reg <= start;
            mul_reg  <= load_reg;
            done_reg <= mul_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg <= key;
        end
        if (load_reg)
        begin
            prod_reg <= PROD_W'(key_reg) * PROD_W'(MUL);
        end
        if (mul_reg)
        begin
            rem_reg <= key_reg[RW-1:0] - quo_lo * BK_LO;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: rtl/modulo_hash_table.sv
// channel  dir  signals                      beat
// req      in   req_valid req_ready req      operation, key, value
// rsp      out  rsp_valid rsp_ready rsp      status, table_empty
//
// one beat at a time: req_ready is high only in idle, so a new beat waits for the final write
// the remainder unit registers the key, a reciprocal multiply and a low-bit reduce, then the ways
// of the bucket are read from the key store one per cycle, plus a drain state for the last read
// after reset a clearing pass over all BUCKETS*WAYS slots runs with req_ready low
// a waiting response holds the final write until rsp_ready frees the output
module modulo_hash_table #(
    parameter int BUCKETS = mht_pkg::BUCKETS_DEF,
    parameter int WAYS    = mht_pkg::WAYS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  mht_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output mht_pkg::rsp_t rsp
);

    localparam int SLOTS  = BUCKETS * WAYS;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RW     = $clog2(BUCKETS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int KEY_W  = mht_pkg::KEY_W;
    localparam int VAL_W  = mht_pkg::VAL_W;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
    localparam logic [SLOT_W-1:0] WAYS_S    = SLOT_W'(WAYS);
    localparam logic [WAY_W-1:0]  WAY_LAST  = WAY_W'(WAYS - 1);

    mht_pkg::state_t state_reg;
    mht_pkg::state_t state_next;

    logic [SLOT_W-1:0] clr_reg;
    logic [WAY_W-1:0]  way_reg;
    logic [WAY_W-1:0]  chk_way_reg;
    logic              match_reg;
    logic [WAY_W-1:0]  match_way_reg;
    logic              free_reg;
    logic [WAY_W-1:0]  free_way_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic              rsp_valid_reg;
    mht_pkg::rsp_t     rsp_reg;

    logic              mod_start;
    logic              mod_done;
    logic [RW-1:0]     bucket;
    logic              check_en;
    logic              fire;
    logic              entry_hit;
    logic [KEY_W:0]    key_rd;
    logic [SLOT_W-1:0] base;
    logic [SLOT_W-1:0] rd_addr;
    logic              key_wr_en;
    logic [SLOT_W-1:0] key_wr_addr;
    logic [KEY_W:0]    key_wr_data;
    logic              val_wr_en;
    logic [SLOT_W-1:0] hit_slot;
    logic [SLOT_W-1:0] free_slot;
    mht_pkg::status_t  status;

    mht_mod #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .key   (req.key),
        .done  (mod_done),
        .rem   (bucket)
    );

    // key store entry: valid bit above the key
    mht_ram #(
        .WIDTH (KEY_W + 1),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (key_wr_addr),
        .wr_data (key_wr_data),
        .rd_addr (rd_addr),
        .rd_data (key_rd)
    );

    mht_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SLOTS)
    ) u_val_ram (
        .clk     (clk),
        .wr_en   (val_wr_en),
        .wr_addr (match_reg ? hit_slot : free_slot),
        .wr_data (val_reg),
        .rd_addr (hit_slot),
        .rd_data ()
    );

    assign base      = SLOT_W'(bucket) * WAYS_S;
    assign rd_addr   = base + SLOT_W'(way_reg);
    assign hit_slot  = base + SLOT_W'(match_way_reg);
    assign free_slot = base + SLOT_W'(free_way_reg);
    assign entry_hit = key_rd[KEY_W] && (key_rd[KEY_W-1:0] == key_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mht_pkg::ST_CLEAR:
            begin
                if (clr_reg == SLOT_LAST)
                begin
                    state_next = mht_pkg::ST_IDLE;
                end
            end
            mht_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = mht_pkg::ST_HASH;
                end
            end
            mht_pkg::ST_HASH:
            begin
                if (mod_done)
                begin
                    state_next = mht_pkg::ST_SCAN;
                end
            end
            mht_pkg::ST_SCAN:
            begin
                if (way_reg == WAY_LAST)
                begin
                    state_next = mht_pkg::ST_DRAIN;
                end
            end
            mht_pkg::ST_DRAIN:
            begin
                state_next = mht_pkg::ST_WRITE;
            end
            mht_pkg::ST_WRITE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = mht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mht_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready   = 1'b0;
        mod_start   = 1'b0;
        check_en    = 1'b0;
        fire        = 1'b0;
        key_wr_en   = 1'b0;
        key_wr_addr = clr_reg;
        key_wr_data = '0;
        val_wr_en   = 1'b0;
        cnt_next    = cnt_reg;
        if (op_reg == mht_pkg::OP_INSERT)
        begin
            status = match_reg ? mht_pkg::STATUS_UPDATED
                   : (free_reg ? mht_pkg::STATUS_INSERTED : mht_pkg::STATUS_FULL);
        end
        else
        begin
            status = match_reg ? mht_pkg::STATUS_REMOVED : mht_pkg::STATUS_NOT_FOUND;
        end
        unique case (state_reg)
            mht_pkg::ST_CLEAR:
            begin
                key_wr_en = 1'b1;
            end
            mht_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                mod_start = req_valid;
            end
            mht_pkg::ST_HASH:
            begin
            end
            mht_pkg::ST_SCAN:
            begin
                check_en = (way_reg != '0);
            end
            mht_pkg::ST_DRAIN:
            begin
                check_en = 1'b1;
            end
            mht_pkg::ST_WRITE:
            begin
                fire = !rsp_valid_reg || rsp_ready;
                if (op_reg == mht_pkg::OP_INSERT)
                begin
                    val_wr_en   = fire && (match_reg || free_reg);
                    key_wr_en   = fire && !match_reg && free_reg;
                    key_wr_addr = free_slot;
                    key_wr_data = {1'b1, key_reg};
                    if (!match_reg && free_reg)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    key_wr_en   = fire && match_reg;
                    key_wr_addr = hit_slot;
                    key_wr_data = {1'b0, key_reg};
                    if (match_reg && (cnt_reg != '0))
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mht_pkg::ST_CLEAR;
            clr_reg       <= '0;
            way_reg       <= '0;
            chk_way_reg   <= '0;
            match_reg     <= 1'b0;
            match_way_reg <= '0;
            free_reg      <= 1'b0;
            free_way_reg  <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            chk_way_reg <= way_reg;
            if (state_reg == mht_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + SLOT_W'(1);
            end
            if (state_reg == mht_pkg::ST_SCAN && way_reg != WAY_LAST)
            begin
                way_reg <= way_reg + WAY_W'(1);
            end
            else
            begin
                way_reg <= '0;
            end
            if (mod_start)
            begin
                match_reg <= 1'b0;
                free_reg  <= 1'b0;
            end
            else if (check_en)
            begin
                if (entry_hit && !match_reg)
                begin
                    match_reg     <= 1'b1;
                    match_way_reg <= chk_way_reg;
                end
                if (!key_rd[KEY_W] && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_way_reg <= chk_way_reg;
                end
            end
            if (fire)
            begin
                cnt_reg       <= cnt_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mod_start)
        begin
            op_reg  <= req.operation;
            key_reg <= req.key;
            val_reg <= req.value;
        end
        if (fire)
        begin
            rsp_reg.status      <= status;
            rsp_reg.table_empty <= (cnt_next == '0);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_accept_to_hash: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg == mht_pkg::ST_HASH)
        else $error("accepted beat did not start the remainder unit");

    a_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> state_reg == mht_pkg::ST_HASH)
        else $error("remainder done outside hash phase");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(SLOTS))
        else $error("entry count above slot count");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        fire && status == mht_pkg::STATUS_INSERTED |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("insert did not bump entry count");

    a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mht_pkg::ST_CLEAR |-> !rsp_valid_reg && !req_ready)
        else $error("handshake active during clearing pass");

endmodule
